### hdl/hsv_to_rgb_converter_assert.svh
// Assertion macros for the HSV to RGB converter checker.
// Depends on nothing; included by the checker file.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSVC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("hsvc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSVC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("hsvc: next-cycle check failed");

`endif

### hdl/hsvc_pkg.sv
// Shared types and constants of the HSV to RGB converter.
// No dependencies; every other file of the block but the assertion macro header uses it.
`timescale 1ns / 1ps

package hsvc_pkg;

	localparam int HUE_W      = 16;
	localparam int PCT_W      = 7;
	localparam int LEVEL_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int ANGLE_W    = 9;   // reduced hue, 0..359
	localparam int T_W        = 6;   // folded offset, 0..60

	// hue / 360 by reciprocal: floor(hue * 11650 / 2^22) is exact or one low
	localparam int HUE_RECIP_W     = 14;
	localparam int HUE_PROD_W      = 30;
	localparam int HUE_Q_W         = 8;
	localparam int HUE_RECIP_SHIFT = 22;
	localparam logic [HUE_RECIP_W-1:0] HUE_RECIP = 14'd11650;
	localparam int REM_W = 17;
	localparam logic [REM_W-1:0] HUE_FULL_W17 = 17'd360;
	localparam logic [ANGLE_W:0] HUE_FULL = 10'd360;

	localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
	localparam logic [PCT_W-1:0] PCT_RESET = 7'd75;
	localparam logic [T_W-1:0]   SECTOR_DEG = 6'd60;

	// level = floor(255 * V * span / 600000), span at most 6000
	localparam int SPAN_W = 13;
	localparam int W_W    = 15;      // 255 * V
	localparam int P_W    = 28;      // 255 * V * span
	localparam logic [SPAN_W-1:0] SPAN_FULL   = 13'd6000;
	localparam logic [SPAN_W-1:0] SPAN_PER_PCT = 13'd60;
	localparam logic [W_W-1:0]    LEVEL_MAX   = 15'd255;
	// ceil(2^48 / 600000); exact for every product below 2^28
	localparam int DIV_RECIP_W = 29;
	localparam int DIV_PROD_W  = 57;
	localparam int DIV_SHIFT   = 48;
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 29'd469124962;

	typedef enum logic [2:0] {
		SECTOR_0, SECTOR_1, SECTOR_2, SECTOR_3, SECTOR_4, SECTOR_5
	} sector_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SATURATION = 2'd0,
		REG_BRIGHTNESS = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		sector_t        sector;
		logic [T_W-1:0] t;
	} hue_entry_t;

	typedef struct packed {
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] bri;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// first degree of each sector
	function automatic logic [ANGLE_W-1:0] sector_base(input sector_t sector);
		logic [ANGLE_W-1:0] base;
		case (sector)
			SECTOR_0: base = 9'd0;
			SECTOR_1: base = 9'd60;
			SECTOR_2: base = 9'd120;
			SECTOR_3: base = 9'd180;
			SECTOR_4: base = 9'd240;
			SECTOR_5: base = 9'd300;
			default:  base = 9'd0;
		endcase
		return base;
	endfunction

endpackage

### hdl/hsvc_if.sv
// Channel interfaces of the HSV to RGB converter: hue in, RGB out, config write.
// Depends on hsvc_pkg for field widths.
`timescale 1ns / 1ps

interface hsvc_hue_if;
	logic                       valid;
	logic                       ready;
	logic [hsvc_pkg::HUE_W-1:0] hue;
	modport source (output valid, output hue, input ready);
	modport sink (input valid, input hue, output ready);
endinterface

interface hsvc_rgb_if;
	logic                         valid;
	logic                         ready;
	logic [hsvc_pkg::LEVEL_W-1:0] red;
	logic [hsvc_pkg::LEVEL_W-1:0] green;
	logic [hsvc_pkg::LEVEL_W-1:0] blue;
	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface hsvc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [hsvc_pkg::CFG_IDX_W-1:0]  index;
	logic [hsvc_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/hsvc_front.sv
// Front end: reduces the hue modulo 360 and classifies it into sector and offset.
// Depends on hsvc_pkg; feeds hsvc_queue.
`timescale 1ns / 1ps

module hsvc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       hue_valid,
	output logic                       hue_ready,
	input  logic [hsvc_pkg::HUE_W-1:0] hue,
	input  hsvc_pkg::queue_stat_t      stat,
	output logic                       push,
	output hsvc_pkg::hue_entry_t       push_entry
);

	logic                             adv;
	logic                             v_s1;
	logic                             v_s2;
	logic [hsvc_pkg::HUE_W-1:0]       hue_s1;
	logic [hsvc_pkg::HUE_Q_W-1:0]     quot_s1;
	logic [hsvc_pkg::ANGLE_W-1:0]     angle_s2;
	logic [hsvc_pkg::HUE_PROD_W-1:0]  hue_prod;
	logic [hsvc_pkg::REM_W-1:0]       quot_x360;
	logic [hsvc_pkg::REM_W-1:0]       rem_wide;
	logic [hsvc_pkg::ANGLE_W:0]       rem;
	logic [hsvc_pkg::ANGLE_W:0]       angle_fix;
	hsvc_pkg::sector_t                sector;
	logic [hsvc_pkg::ANGLE_W-1:0]     offset;
	logic [hsvc_pkg::T_W-1:0]         off6;

	// stall only when the last stage holds an item the queue cannot take
	assign adv       = !(v_s2 && stat.full);
	assign hue_ready = adv;
	assign push      = v_s2 && !stat.full;

	assign hue_prod = {{(hsvc_pkg::HUE_PROD_W-hsvc_pkg::HUE_W){1'b0}}, hue}
		* {{(hsvc_pkg::HUE_PROD_W-hsvc_pkg::HUE_RECIP_W){1'b0}}, hsvc_pkg::HUE_RECIP};

	// quotient estimate may be one low: one conditional subtract fixes it
	assign quot_x360 = {{(hsvc_pkg::REM_W-hsvc_pkg::HUE_Q_W){1'b0}}, quot_s1}
		* hsvc_pkg::HUE_FULL_W17;
	assign rem_wide  = {{(hsvc_pkg::REM_W-hsvc_pkg::HUE_W){1'b0}}, hue_s1} - quot_x360;
	assign rem       = rem_wide[hsvc_pkg::ANGLE_W:0];
	assign angle_fix = (rem >= hsvc_pkg::HUE_FULL) ? (rem - hsvc_pkg::HUE_FULL) : rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= hue_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_s1   <= hue;
			quot_s1  <= hue_prod[hsvc_pkg::HUE_RECIP_SHIFT +: hsvc_pkg::HUE_Q_W];
			angle_s2 <= angle_fix[hsvc_pkg::ANGLE_W-1:0];
		end
	end

	always_comb begin
		if (angle_s2 < 9'd60) begin
			sector = hsvc_pkg::SECTOR_0;
		end else if (angle_s2 < 9'd120) begin
			sector = hsvc_pkg::SECTOR_1;
		end else if (angle_s2 < 9'd180) begin
			sector = hsvc_pkg::SECTOR_2;
		end else if (angle_s2 < 9'd240) begin
			sector = hsvc_pkg::SECTOR_3;
		end else if (angle_s2 < 9'd300) begin
			sector = hsvc_pkg::SECTOR_4;
		end else begin
			sector = hsvc_pkg::SECTOR_5;
		end
	end

	// odd sectors run down the 120-degree span, so fold the offset
	assign offset = angle_s2 - hsvc_pkg::sector_base(sector);
	assign off6   = offset[hsvc_pkg::T_W-1:0];

	assign push_entry.sector = sector;
	assign push_entry.t      = sector[0] ? (hsvc_pkg::SECTOR_DEG - off6) : off6;

endmodule

### hdl/hsvc_queue.sv
// Short queue between front and back end of the converter.
// Depends on hsvc_pkg for the entry and status types.
`timescale 1ns / 1ps

module hsvc_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  hsvc_pkg::hue_entry_t  push_entry,
	input  logic                  pop,
	output hsvc_pkg::hue_entry_t  pop_entry,
	output hsvc_pkg::queue_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hsvc_pkg::hue_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### hdl/hsvc_back.sv
// Back end: computes the V, m and X+m levels and routes them by sector.
// Depends on hsvc_pkg; drains hsvc_queue.
`timescale 1ns / 1ps

module hsvc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hsvc_pkg::cfg_t               cfg,
	input  hsvc_pkg::queue_stat_t        stat,
	output logic                         pop,
	input  hsvc_pkg::hue_entry_t         pop_entry,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hsvc_pkg::LEVEL_W-1:0] red,
	output logic [hsvc_pkg::LEVEL_W-1:0] green,
	output logic [hsvc_pkg::LEVEL_W-1:0] blue
);

	logic                               adv;
	logic                               v_b1, v_b2, v_b3, v_q;
	hsvc_pkg::sector_t                  sector_b1, sector_b2, sector_b3;
	logic [hsvc_pkg::SPAN_W-1:0]        ax_b1, am_b1;
	logic [hsvc_pkg::W_W-1:0]           w_b1;
	logic [hsvc_pkg::P_W-1:0]           px_b2, pm_b2, pv_b2;
	logic [hsvc_pkg::LEVEL_W-1:0]       lx_b3, lm_b3, lv_b3;
	logic [hsvc_pkg::LEVEL_W-1:0]       red_q, green_q, blue_q;
	logic [hsvc_pkg::SPAN_W-1:0]        sat_t;
	logic [hsvc_pkg::PCT_W-1:0]         compl;
	logic [hsvc_pkg::SPAN_W-1:0]        am;
	logic [hsvc_pkg::DIV_PROD_W-1:0]    qx, qm, qv;
	logic [hsvc_pkg::LEVEL_W-1:0]       r_n, g_n, b_n;

	assign adv = !v_q || out_ready;
	assign pop = adv && !stat.empty;

	// span terms: X+m uses S*t + 60*(100-S), m uses 60*(100-S)
	assign sat_t = {{(hsvc_pkg::SPAN_W-hsvc_pkg::PCT_W){1'b0}}, cfg.sat}
		* {{(hsvc_pkg::SPAN_W-hsvc_pkg::T_W){1'b0}}, pop_entry.t};
	assign compl = hsvc_pkg::PCT_MAX - cfg.sat;
	assign am    = {{(hsvc_pkg::SPAN_W-hsvc_pkg::PCT_W){1'b0}}, compl}
		* hsvc_pkg::SPAN_PER_PCT;

	// divide by 600000 through a reciprocal that is exact over the range
	assign qx = {{(hsvc_pkg::DIV_PROD_W-hsvc_pkg::P_W){1'b0}}, px_b2}
		* {{(hsvc_pkg::DIV_PROD_W-hsvc_pkg::DIV_RECIP_W){1'b0}}, hsvc_pkg::DIV_RECIP};
	assign qm = {{(hsvc_pkg::DIV_PROD_W-hsvc_pkg::P_W){1'b0}}, pm_b2}
		* {{(hsvc_pkg::DIV_PROD_W-hsvc_pkg::DIV_RECIP_W){1'b0}}, hsvc_pkg::DIV_RECIP};
	assign qv = {{(hsvc_pkg::DIV_PROD_W-hsvc_pkg::P_W){1'b0}}, pv_b2}
		* {{(hsvc_pkg::DIV_PROD_W-hsvc_pkg::DIV_RECIP_W){1'b0}}, hsvc_pkg::DIV_RECIP};

	always_comb begin
		case (sector_b3)
			hsvc_pkg::SECTOR_0: begin r_n = lv_b3; g_n = lx_b3; b_n = lm_b3; end
			hsvc_pkg::SECTOR_1: begin r_n = lx_b3; g_n = lv_b3; b_n = lm_b3; end
			hsvc_pkg::SECTOR_2: begin r_n = lm_b3; g_n = lv_b3; b_n = lx_b3; end
			hsvc_pkg::SECTOR_3: begin r_n = lm_b3; g_n = lx_b3; b_n = lv_b3; end
			hsvc_pkg::SECTOR_4: begin r_n = lx_b3; g_n = lm_b3; b_n = lv_b3; end
			default:            begin r_n = lv_b3; g_n = lm_b3; b_n = lx_b3; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_q  <= 1'b0;
		end else if (adv) begin
			v_b1 <= !stat.empty;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_q  <= v_b3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_b1 <= pop_entry.sector;
			ax_b1     <= sat_t + am;
			am_b1     <= am;
			w_b1      <= {{(hsvc_pkg::W_W-hsvc_pkg::PCT_W){1'b0}}, cfg.bri}
				* hsvc_pkg::LEVEL_MAX;

			sector_b2 <= sector_b1;
			px_b2     <= {{(hsvc_pkg::P_W-hsvc_pkg::W_W){1'b0}}, w_b1}
				* {{(hsvc_pkg::P_W-hsvc_pkg::SPAN_W){1'b0}}, ax_b1};
			pm_b2     <= {{(hsvc_pkg::P_W-hsvc_pkg::W_W){1'b0}}, w_b1}
				* {{(hsvc_pkg::P_W-hsvc_pkg::SPAN_W){1'b0}}, am_b1};
			pv_b2     <= {{(hsvc_pkg::P_W-hsvc_pkg::W_W){1'b0}}, w_b1}
				* {{(hsvc_pkg::P_W-hsvc_pkg::SPAN_W){1'b0}}, hsvc_pkg::SPAN_FULL};

			sector_b3 <= sector_b2;
			lx_b3     <= qx[hsvc_pkg::DIV_SHIFT +: hsvc_pkg::LEVEL_W];
			lm_b3     <= qm[hsvc_pkg::DIV_SHIFT +: hsvc_pkg::LEVEL_W];
			lv_b3     <= qv[hsvc_pkg::DIV_SHIFT +: hsvc_pkg::LEVEL_W];

			red_q     <= r_n;
			green_q   <= g_n;
			blue_q    <= b_n;
		end
	end

	assign out_valid = v_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

endmodule

### hdl/hsv_to_rgb_converter.sv
// HSV to RGB converter, top: one hue in, one RGB triple out per clock unless stalled.
// Depends on hsvc_pkg, hsvc_if, hsvc_front, hsvc_queue and hsvc_back.
// Usage: each hue request (any 16-bit value, taken modulo 360) yields exactly one
// red/green/blue request, in order, from the saturation and brightness percentages
// held in configuration registers 0 and 1 (reset 75; written values are masked to
// 7 bits and clamped to 100). Sustained rate is one item per clock while rgb_ch is
// ready. From acceptance to the result on rgb_ch an item passes two front stages
// (reciprocal multiply for hue / 360, then remainder fix and sector classification),
// the queue, three back stages (span terms, 255*V*span, multiply by the reciprocal
// of 600000) and the output register. The queue of QUEUE_DEPTH entries lets the
// front keep taking hues while a stalled output holds the back end.
// Configuration writes are always ready and must only be issued while idle.
`timescale 1ns / 1ps

module hsv_to_rgb_converter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	hsvc_hue_if.sink   hue_ch,
	hsvc_rgb_if.source rgb_ch,
	hsvc_cfg_if.sink   cfg_ch
);

	hsvc_pkg::cfg_t                 cfg_q;
	hsvc_pkg::queue_stat_t          stat;
	hsvc_pkg::hue_entry_t           push_entry;
	hsvc_pkg::hue_entry_t           pop_entry;
	logic                           push;
	logic                           pop;
	logic [hsvc_pkg::PCT_W-1:0]     wr_pct;

	// config port never stalls
	assign cfg_ch.ready = 1'b1;

	// mask to 7 bits, clamp to 100
	assign wr_pct = (cfg_ch.data[hsvc_pkg::PCT_W-1:0] > hsvc_pkg::PCT_MAX)
		? hsvc_pkg::PCT_MAX : cfg_ch.data[hsvc_pkg::PCT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sat <= hsvc_pkg::PCT_RESET;
			cfg_q.bri <= hsvc_pkg::PCT_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				hsvc_pkg::REG_SATURATION: cfg_q.sat <= wr_pct;
				hsvc_pkg::REG_BRIGHTNESS: cfg_q.bri <= wr_pct;
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	// front: hue mod 360, sector and folded offset
	hsvc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hue_valid  (hue_ch.valid),
		.hue_ready  (hue_ch.ready),
		.hue        (hue_ch.hue),
		.stat       (stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples the two halves so each can stall on its own
	hsvc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.stat       (stat)
	);

	// back: level arithmetic and channel routing, output register
	hsvc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.stat      (stat),
		.pop       (pop),
		.pop_entry (pop_entry),
		.out_valid (rgb_ch.valid),
		.out_ready (rgb_ch.ready),
		.red       (rgb_ch.red),
		.green     (rgb_ch.green),
		.blue      (rgb_ch.blue)
	);

endmodule

### hdl/hsvc_checker.sv
// Port-level checker of the HSV to RGB converter, bound to the top level.
// Depends on hsvc_pkg and hsv_to_rgb_converter_assert.svh.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_assert.svh"

module hsvc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [hsvc_pkg::LEVEL_W-1:0]    red,
	input logic [hsvc_pkg::LEVEL_W-1:0]    green,
	input logic [hsvc_pkg::LEVEL_W-1:0]    blue,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [hsvc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [hsvc_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [hsvc_pkg::PCT_W-1:0] sat_q;
	logic [hsvc_pkg::PCT_W-1:0] bri_q;
	logic [hsvc_pkg::PCT_W-1:0] wr_pct;

	assign wr_pct = (cfg_data[hsvc_pkg::PCT_W-1:0] > hsvc_pkg::PCT_MAX)
		? hsvc_pkg::PCT_MAX : cfg_data[hsvc_pkg::PCT_W-1:0];

	// shadow copy of the settings as seen on the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= hsvc_pkg::PCT_RESET;
			bri_q <= hsvc_pkg::PCT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hsvc_pkg::REG_SATURATION: sat_q <= wr_pct;
				hsvc_pkg::REG_BRIGHTNESS: bri_q <= wr_pct;
				default: ;
			endcase
		end
	end

	`HSVC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`HSVC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(red) && $stable(green) && $stable(blue))
	// zero brightness gives black whatever the hue
	`HSVC_ASSERT_NOW(a_dark, clk, arst_n, out_valid && (bri_q == '0), (red == '0) && (green == '0) && (blue == '0))
	// zero saturation gives a gray: all channels equal
	`HSVC_ASSERT_NOW(a_gray, clk, arst_n, out_valid && (sat_q == '0), (red == green) && (green == blue))

endmodule

bind hsv_to_rgb_converter hsvc_checker u_hsvc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rgb_ch.valid),
	.out_ready (rgb_ch.ready),
	.red       (rgb_ch.red),
	.green     (rgb_ch.green),
	.blue      (rgb_ch.blue),
	.cfg_valid (cfg_ch.valid),
	.cfg_ready (cfg_ch.ready),
	.cfg_index (cfg_ch.index),
	.cfg_data  (cfg_ch.data)
);
